FILE: src/bol_pkg.sv
// shared types and codes for the bounded ordered list
package bol_pkg;

    // widest index or count the cell row ever needs (capacity up to 127)
    localparam int unsigned CTL_W = 7;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_INSERT     = 3'd3,
        MODE_ERASE      = 3'd4,
        MODE_DUMP       = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_BADPOS = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    typedef struct packed {
        mode_t              mode;
        logic [3:0]         position;
        logic signed [31:0] value_in;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] value_out;
        logic               last;
        logic [4:0]         count;
    } rsp_t;

    // broadcast to every cell in the row
    typedef struct packed {
        cell_op_t           op;
        logic [CTL_W-1:0]   pos;
        logic [CTL_W-1:0]   count;
        logic signed [31:0] value;
    } cell_ctl_t;

endpackage

FILE: src/bol_cell.sv
// one list entry of the cell row, shifting or rotating with its neighbours
module bol_cell
    import bol_pkg::*;
#(
    parameter int unsigned INDEX = 0
)
(
    input  logic               clk,
    input  cell_ctl_t          ctl,
    input  logic signed [31:0] left_data,
    input  logic signed [31:0] right_data,
    input  logic signed [31:0] head_data,
    output logic signed [31:0] data
);

    localparam logic [CTL_W-1:0] IDX = CTL_W'(INDEX);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    // select the new entry value from the broadcast operation
    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_INSERT:
            begin
                if (IDX > ctl.pos)
                begin
                    data_next = left_data;
                end
                else if (IDX == ctl.pos)
                begin
                    data_next = ctl.value;
                end
            end
            CELL_ERASE:
            begin
                if (IDX >= ctl.pos)
                begin
                    data_next = right_data;
                end
            end
            CELL_ROTATE:
            begin
                if (IDX + 1'b1 < ctl.count)
                begin
                    data_next = right_data;
                end
                else if (IDX + 1'b1 == ctl.count)
                begin
                    data_next = head_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // entry payload, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: src/bounded_ordered_list_top.sv
// top level: request decode, dump sequencer and the row of list cells
// an edit request gives its single response, registered, in the cycle after acceptance
// throughput: one edit request per cycle while responses are taken and no dump is running
// a dump of n entries rotates them out of cell 0, one entry per cycle while responses are taken
// the dump rotation over the first n cells leaves the list in its original order
// reset: asynchronous active-low, list empty, entry values undefined until written
module bounded_ordered_list_top
    import bol_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = (CW > 4) ? CW : 4;

    state_t             state_reg;
    state_t             state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    cell_ctl_t          ctl;
    logic               accept;
    logic               slot_free;
    logic               dump_step;
    logic               pos_ok;
    logic               full;
    logic               dump_start;
    logic signed [31:0] cell_data [CAPACITY];

    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = !((state_reg == ST_IDLE) && slot_free);
    assign accept     = req_valid && !req_stall;
    assign dump_step  = (state_reg == ST_DUMP) && slot_free;
    assign pos_ok     = PW'(req.position) < PW'(count_reg);
    assign full       = count_reg == CW'(CAPACITY);
    assign dump_start = accept && (req.mode == MODE_DUMP) && (count_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (dump_start)
                begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                if (dump_step && (idx_reg + 1'b1 == count_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // request decode, cell control and response
    always_comb
    begin
        ctl            = '{op: CELL_HOLD, pos: '0, count: CTL_W'(count_reg),
                           value: req.value_in};
        count_next     = count_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (accept)
        begin
            rsp_next = '{status: STATUS_OK, value_out: '0, last: 1'b1, count: '0};
            idx_next = '0;
            case (req.mode)
                MODE_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        ctl.op     = CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        ctl.op     = CELL_INSERT;
                        ctl.pos    = CTL_W'(count_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_POP_BACK:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                MODE_INSERT:
                begin
                    if (!pos_ok)
                    begin
                        rsp_next.status = STATUS_BADPOS;
                    end
                    else if (full)
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        ctl.op     = CELL_INSERT;
                        ctl.pos    = CTL_W'(req.position);
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_ERASE:
                begin
                    if (!pos_ok)
                    begin
                        rsp_next.status = STATUS_BADPOS;
                    end
                    else
                    begin
                        ctl.op     = CELL_ERASE;
                        ctl.pos    = CTL_W'(req.position);
                        count_next = count_reg - 1'b1;
                    end
                end
                MODE_DUMP:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next.status = STATUS_EMPTY;
                    end
                end
                default:
                begin
                    rsp_next.status = STATUS_OK;
                end
            endcase
            rsp_next.count = 5'(count_next);
            rsp_valid_next = !dump_start;
        end
        else if (dump_step)
        begin
            ctl.op         = CELL_ROTATE;
            idx_next       = idx_reg + 1'b1;
            rsp_valid_next = 1'b1;
            rsp_next       = '{status: STATUS_OK, value_out: cell_data[0],
                               last: (idx_reg + 1'b1 == count_reg),
                               count: 5'(count_reg)};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // row of list cells, cell 0 at the front
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        bol_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

`ifndef SYNTHESIS
    // occupancy never exceeds the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("list count above capacity");

    // dump index stays inside the list
    a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (idx_reg < count_reg))
        else $error("dump index beyond list");

    // no request taken while a dump is running
    a_dump_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> req_stall)
        else $error("request accepted during dump");

    // an edit request always gives a response in the next cycle
    a_edit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.mode != MODE_DUMP)) |=> (rsp_valid_reg && rsp_reg.last))
        else $error("edit request without response");
`endif

endmodule

FILE: tb/bounded_ordered_list_top_tb.sv
// self-checking testbench for the bounded ordered list: shadow list predictor and response checks
module bounded_ordered_list_top_tb;
    import bol_pkg::*;

    localparam int LIST_CAP        = 16;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int SETTLE_CYCLES   = 20;
    localparam int RUN_LIMIT       = 4000000;

    // modes outside the decoded set, still legal on the wire
    localparam mode_t MODE_SPARE_LO = mode_t'(3'd6);
    localparam mode_t MODE_SPARE_HI = mode_t'(3'd7);

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_style_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // shadow copy of the list contents
    logic signed [31:0] list_vals [LIST_CAP];
    int list_len = 0;

    rsp_t expected_rsp_q [$];
    int mismatch_count    = 0;
    int responses_checked = 0;
    int mode_seen [8];
    int burst_left        = 0;
    bit hold_off_request  = 1'b0;

    bounded_ordered_list_top #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // overall run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout: %0d responses still outstanding", expected_rsp_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // shift the tail up and place a value, unless the list is full
    function automatic status_t place_value(input int at, input logic signed [31:0] v);
        if (list_len >= LIST_CAP)
            return STATUS_FULL;
        for (int i = list_len; i > at; i--)
            list_vals[i] = list_vals[i - 1];
        list_vals[at] = v;
        list_len++;
        return STATUS_OK;
    endfunction

    // apply one accepted request to the shadow list and queue its responses
    function automatic void apply_list_request(input req_t r);
        rsp_t    want;
        status_t st;
        int      p;
        st = STATUS_OK;
        p  = int'(r.position);
        mode_seen[r.mode]++;
        case (r.mode)
            MODE_PUSH_FRONT: st = place_value(0, r.value_in);
            MODE_PUSH_BACK:  st = place_value(list_len, r.value_in);
            MODE_POP_BACK:
            begin
                if (list_len == 0)
                    st = STATUS_EMPTY;
                else
                    list_len--;
            end
            MODE_INSERT:
            begin
                if (p >= list_len)
                    st = STATUS_BADPOS;
                else
                    st = place_value(p, r.value_in);
            end
            MODE_ERASE:
            begin
                if (p >= list_len)
                    st = STATUS_BADPOS;
                else
                begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_len--;
                end
            end
            MODE_DUMP:
            begin
                if (list_len == 0)
                    st = STATUS_EMPTY;
                else
                begin
                    // one response per entry, front first
                    for (int i = 0; i < list_len; i++)
                    begin
                        want.status    = STATUS_OK;
                        want.value_out = list_vals[i];
                        want.last      = (i + 1 == list_len);
                        want.count     = 5'(list_len);
                        expected_rsp_q.insert(expected_rsp_q.size(), want);
                    end
                    return;
                end
            end
            default: ;
        endcase
        want.status    = st;
        want.value_out = '0;
        want.last      = 1'b1;
        want.count     = 5'(list_len);
        expected_rsp_q.insert(expected_rsp_q.size(), want);
    endfunction

    function automatic req_t make_req(input mode_t m, input int pos,
                                      input logic signed [31:0] v);
        req_t r;
        r.mode     = m;
        r.position = 4'(pos);
        r.value_in = v;
        return r;
    endfunction

    // values leaning towards the extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // offer one request in bursts with random gaps, predict on acceptance
    task automatic send_request(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= r;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        apply_list_request(r);
    endtask

    // stop offering until every queued response has come back
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver stall patterns, with one long hold-off
    initial
    begin : rsp_side
        stall_style_t style;
        int           style_left;
        bit           hold_off_done;
        rsp_stall <= 1'b0;
        style         = STALL_NONE;
        style_left    = 40;
        hold_off_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if (style_left == 0)
            begin
                style      = stall_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 80);
            end
            style_left--;
            case (style)
                STALL_NONE:     rsp_stall <= 1'b0;
                STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: rsp_stall <= (style_left % 3 == 0);
                default:        rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // compare each accepted response with the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
                report_mismatch($sformatf(
                    "unexpected response status %0d value %0d last %0d count %0d",
                    rsp.status, rsp.value_out, rsp.last, rsp.count));
            else
            begin
                want = expected_rsp_q.pop_front();
                responses_checked++;
                if (rsp.status !== want.status || rsp.value_out !== want.value_out ||
                    rsp.last !== want.last || rsp.count !== want.count)
                    report_mismatch($sformatf(
                        "got status %0d value %0d last %0d count %0d, want %0d %0d %0d %0d",
                        rsp.status, rsp.value_out, rsp.last, rsp.count,
                        want.status, want.value_out, want.last, want.count));
            end
        end
    end

    // dump, pop, erase and insert requests against an empty list
    task automatic test_empty_list();
        send_request(make_req(MODE_DUMP, 0, 32'sh0));
        send_request(make_req(MODE_POP_BACK, 0, 32'sh0));
        send_request(make_req(MODE_ERASE, 0, 32'sh0));
        send_request(make_req(MODE_INSERT, 0, 32'sh1234_5678));
        send_request(make_req(MODE_ERASE, 15, 32'sh0));
    endtask

    // edits at both ends and in the middle, extreme values, bad positions
    task automatic test_edits_and_extremes();
        send_request(make_req(MODE_PUSH_BACK, 0, 32'sh7FFF_FFFF));
        send_request(make_req(MODE_PUSH_FRONT, 15, 32'sh8000_0000));
        send_request(make_req(MODE_INSERT, 0, -32'sd1));
        send_request(make_req(MODE_INSERT, 2, 32'sh0));
        send_request(make_req(MODE_INSERT, 15, 32'sh5A5A_A5A5));
        send_request(make_req(MODE_DUMP, 0, 32'sh0));
        // erase at the front must lower the count
        send_request(make_req(MODE_ERASE, 0, 32'sh0));
        send_request(make_req(MODE_ERASE, 2, 32'sh0));
        send_request(make_req(MODE_ERASE, 2, 32'sh0));
        send_request(make_req(MODE_POP_BACK, 0, 32'sh0));
        send_request(make_req(MODE_DUMP, 0, 32'sh0));
        send_request(make_req(MODE_POP_BACK, 0, 32'sh0));
        send_request(make_req(MODE_POP_BACK, 0, 32'sh0));
    endtask

    // undecoded modes leave the list alone
    task automatic test_spare_modes();
        send_request(make_req(MODE_PUSH_BACK, 0, 32'sh0F0F_F0F0));
        send_request(make_req(MODE_SPARE_LO, 15, $urandom));
        send_request(make_req(MODE_SPARE_HI, 0, $urandom));
        send_request(make_req(MODE_DUMP, 0, 32'sh0));
    endtask

    // fill past capacity while the receiver holds off, then work on a full list
    task automatic test_fill_under_backpressure();
        hold_off_request = 1'b1;
        for (int i = 0; i < LIST_CAP + 3; i++)
            send_request(make_req((i % 2 != 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                                  $urandom_range(0, 15), pick_value()));
        send_request(make_req(MODE_INSERT, 15, pick_value()));
        send_request(make_req(MODE_DUMP, 0, 32'sh0));
        send_request(make_req(MODE_ERASE, 15, 32'sh0));
        send_request(make_req(MODE_INSERT, 15, pick_value()));
        send_request(make_req(MODE_ERASE, 0, 32'sh0));
        send_request(make_req(MODE_DUMP, 0, 32'sh0));
    endtask

    // mostly well-formed edits with random content, drifting between empty and full
    task automatic test_random_traffic(input int n_items);
        req_t r;
        int   roll;
        bit   growing;
        growing = 1'b0;
        for (int n = 0; n < n_items; n++)
        begin
            if (list_len == LIST_CAP)
                growing = 1'b0;
            else if (list_len == 0 || $urandom_range(0, 19) == 0)
                growing = (list_len == 0) ? 1'b1 : ~growing;
            r.position = 4'($urandom_range(0, 15));
            r.value_in = pick_value();
            roll = $urandom_range(0, 99);
            if (roll < 3)
                r.mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;
            else if (roll < 13)
                r.mode = MODE_DUMP;
            else if (roll < (growing ? 55 : 28))
                r.mode = ($urandom_range(0, 1) != 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            else if (roll < (growing ? 78 : 50))
                r.mode = MODE_INSERT;
            else if (roll < (growing ? 92 : 78))
                r.mode = MODE_ERASE;
            else
                r.mode = MODE_POP_BACK;
            // keep most positions inside the list
            if ((r.mode == MODE_INSERT || r.mode == MODE_ERASE) && list_len > 0 &&
                $urandom_range(0, 99) < 85)
                r.position = 4'($urandom_range(0, list_len - 1));
            send_request(r);
        end
    endtask

    // main sequence
    initial
    begin : main_seq
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        foreach (mode_seen[i])
            mode_seen[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edits_and_extremes();
        test_spare_modes();
        test_fill_under_backpressure();
        test_random_traffic(112);
        // full pause with nothing in flight
        wait_for_drain();
        test_random_traffic(111);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d push front, %0d push back, %0d pop, %0d insert, %0d erase,",
                 mode_seen[MODE_PUSH_FRONT], mode_seen[MODE_PUSH_BACK],
                 mode_seen[MODE_POP_BACK], mode_seen[MODE_INSERT], mode_seen[MODE_ERASE]);
        $display("%0d dump, %0d spare; %0d responses checked, %0d mismatches",
                 mode_seen[MODE_DUMP], mode_seen[MODE_SPARE_LO] + mode_seen[MODE_SPARE_HI],
                 responses_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
src/bol_pkg.sv
src/bol_cell.sv
src/bounded_ordered_list_top.sv
tb/bounded_ordered_list_top_tb.sv
